### src/percent_escape_decoder_macros.svh
// Assertion macros for the percent escape decoder.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PERCENT_ESCAPE_DECODER_MACROS_SVH
`define PERCENT_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pcd_pkg.sv
// Shared types for the percent escape decoder.
// No dependencies.
`timescale 1ns / 1ps

package pcd_pkg;

  localparam int unsigned MaxWords = 3;

  // One decoded word as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pcd_word_t;

  // All words produced by one input byte, in order from index 0.
  typedef struct packed {
    logic [1:0]                   count;
    pcd_word_t [MaxWords-1:0]     words;
  } pcd_group_t;

  // Status of the result queue toward the decoder stage.
  typedef struct packed {
    logic space;
  } pcd_q_status_t;

endpackage

### src/pcd_if.sv
// Stream interfaces for the encoded input and the decoded output.
// No dependencies.
`timescale 1ns / 1ps

interface pcd_in_if;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output in_valid, output in_byte, output in_last, input in_ready);
  modport sink   (input in_valid, input in_byte, input in_last, output in_ready);
endinterface

interface pcd_out_if;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output out_valid, output out_byte, output out_last, input out_ready);
  modport sink   (input out_valid, input out_byte, input out_last, output out_ready);
endinterface

### src/pcd_decode.sv
// Escape decoder: holds the pending '%' state and turns one byte into a word group.
// Depends on pcd_pkg.
`timescale 1ns / 1ps

module pcd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         s_byte,
  input  logic               s_last,
  input  logic               take,
  output pcd_pkg::pcd_group_t grp
);
  import pcd_pkg::*;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic       pend_r, pend_nxt;
  logic       held_r, held_nxt;
  logic [7:0] hbyte_r, hbyte_nxt;

  logic [4:0] cur_hex;
  logic [4:0] held_hex;
  logic [7:0] mapped;

  assign cur_hex  = hex_val(s_byte);
  assign held_hex = hex_val(hbyte_r);
  assign mapped   = (s_byte == PLUS_CHAR) ? SPACE_CHAR : s_byte;

  always_comb begin
    logic [1:0]       n;
    logic [7:0]       w [MaxWords];
    logic             is_pct;
    n         = 2'd0;
    w[0]      = 8'h00;
    w[1]      = 8'h00;
    w[2]      = 8'h00;
    is_pct    = (s_byte == PCT_CHAR);
    pend_nxt  = pend_r;
    held_nxt  = held_r;
    hbyte_nxt = hbyte_r;

    if (!pend_r) begin
      if (is_pct) begin
        pend_nxt = 1'b1;
        held_nxt = 1'b0;
      end else begin
        w[n] = mapped;
        n    = n + 2'd1;
      end
    end else if (!held_r) begin
      if (cur_hex[4]) begin
        held_nxt  = 1'b1;
        hbyte_nxt = s_byte;
      end else begin
        // Broken escape: release the '%' and look at this byte afresh.
        w[n] = PCT_CHAR;
        n    = n + 2'd1;
        if (is_pct) begin
          held_nxt = 1'b0;
        end else begin
          pend_nxt = 1'b0;
          w[n]     = mapped;
          n        = n + 2'd1;
        end
      end
    end else begin
      held_nxt = 1'b0;
      if (cur_hex[4]) begin
        pend_nxt = 1'b0;
        w[n]     = {held_hex[3:0], cur_hex[3:0]};
        n        = n + 2'd1;
      end else begin
        w[n] = PCT_CHAR;
        n    = n + 2'd1;
        w[n] = hbyte_r;
        n    = n + 2'd1;
        if (!is_pct) begin
          pend_nxt = 1'b0;
          w[n]     = mapped;
          n        = n + 2'd1;
        end
      end
    end

    // End of string flushes an unfinished escape literally.
    if (s_last) begin
      if (pend_nxt) begin
        w[n] = PCT_CHAR;
        n    = n + 2'd1;
        if (held_nxt) begin
          w[n] = hbyte_nxt;
          n    = n + 2'd1;
        end
      end
      pend_nxt = 1'b0;
      held_nxt = 1'b0;
    end

    grp.count = n;
    for (int i = 0; i < MaxWords; i++) begin
      grp.words[i].data = w[i];
      grp.words[i].last = s_last && (n == 2'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= 1'b0;
    end else if (take) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hbyte_r <= hbyte_nxt;
    end
  end

endmodule

### src/pcd_out_queue.sv
// Result queue: holds up to three words; presents one per cycle when out_ready.
// Depends on pcd_pkg and pcd_out_if.
`timescale 1ns / 1ps

module pcd_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pcd_pkg::pcd_group_t    grp,
  input  logic                   load,
  output pcd_pkg::pcd_q_status_t status,
  pcd_out_if.source              out_if
);
  import pcd_pkg::*;

  logic [1:0]                cnt_r, cnt_nxt;
  pcd_word_t [MaxWords-1:0]  words_r, words_nxt;
  logic                      pop;

  assign pop           = (cnt_r != 2'd0) && out_if.out_ready;
  assign out_if.out_valid = (cnt_r != 2'd0);
  assign out_if.out_byte  = words_r[0].data;
  assign out_if.out_last  = words_r[0].last;

  // A new group may land when the queue drains in this cycle.
  assign status.space = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_if.out_ready);

  always_comb begin
    cnt_nxt   = cnt_r;
    words_nxt = words_r;
    if (load && grp.count != 2'd0) begin
      cnt_nxt   = grp.count;
      words_nxt = grp.words;
    end else if (pop) begin
      cnt_nxt      = cnt_r - 2'd1;
      words_nxt[0] = words_r[1];
      words_nxt[1] = words_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
  end

endmodule

### src/percent_escape_decoder.sv
// Percent escape decoder top level: input register, decoder, result queue.
// An accepted byte is registered in the input stage, then in the result queue.
// Throughput: one byte per cycle if out_ready is high and a byte yields at most
// one word; otherwise the input stage holds until the queue can take a group.
// Reset (synchronous, rst_n low) empties both stages and clears escape state.
`timescale 1ns / 1ps
`include "percent_escape_decoder_macros.svh"

module percent_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  pcd_in_if.sink     in_if,
  pcd_out_if.source  out_if
);
  import pcd_pkg::*;

  logic           s_valid_r;
  logic [7:0]     s_byte_r;
  logic           s_last_r;
  logic           take;
  pcd_group_t     grp;
  pcd_q_status_t  q_status;

  assign take            = s_valid_r && ((grp.count == 2'd0) || q_status.space);
  assign in_if.in_ready  = !s_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_if.in_ready) begin
      s_valid_r <= in_if.in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.in_ready && in_if.in_valid) begin
      s_byte_r <= in_if.in_byte;
      s_last_r <= in_if.in_last;
    end
  end

  pcd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_byte (s_byte_r),
    .s_last (s_last_r),
    .take   (take),
    .grp    (grp)
  );

  pcd_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .grp    (grp),
    .load   (take),
    .status (q_status),
    .out_if (out_if)
  );

  `PCD_ASSERT_NEXT(a_group_shows, take && grp.count != 2'd0, out_if.out_valid, "decoded words not presented")
  `PCD_ASSERT_NOW(a_last_has_word, take && s_last_r, grp.count != 2'd0, "end of string produced no word")
  `PCD_ASSERT_NEXT(a_stage_holds, s_valid_r && !take, s_valid_r && $stable(s_byte_r), "stalled input word changed")

endmodule
